@@ sv/slsp_pkg.sv @@
`default_nettype none

package slsp_pkg;

   // Fixed field widths of the pixel channels
   localparam int IN_W   = 16;
   localparam int BYTE_W = 8;
   localparam int NRGB   = 3;

   // Number of byte boundaries (0..254) in each threshold table
   localparam int NTH = (1 << BYTE_W) - 1;

   // Exact-compare arithmetic for the power segment, wide enough for
   // m^5 * 538050^12 at the largest supported fraction width
   localparam int BN_W = 400;
   typedef logic [BN_W-1:0] bn_type;

   // 510 * 1055: scales the byte boundaries of the power curve to integers
   localparam longint SRGB_K   = 538050;
   // Byte boundary k of the power curve sits at a_k = (2k+1)*1000 + A_OFS
   localparam longint A_STEP   = 1000;
   localparam longint A_OFS    = 28050;
   // Linear segment: byte = 16473 * m / (5 * den), boundary compare uses 2*16473
   localparam longint LIN_DIV  = 32946;
   localparam longint LIN_MUL  = 5;
   // Linear segment end: m * 1292000 <= 4045 * den
   localparam longint LIN_END_NUM = 4045;
   localparam longint LIN_END_DEN = 1292000;

   // Largest m (unit value m / 2^(frac+1)) whose power-curve byte is at most k.
   // A value that lands exactly on an odd boundary rounds up to the even byte,
   // so that boundary moves down by one.
   function automatic logic [31:0] srgb_thresh(input int frac, input int k);
      bn_type c12;
      bn_type rhs;
      bn_type lhs;
      bn_type mm;
      longint a;
      longint den;
      longint lo;
      longint hi;
      longint mid;
      c12 = bn_type'(1);
      rhs = bn_type'(1);
      a   = longint'(2 * k + 1) * A_STEP + A_OFS;
      den = longint'(1) << (frac + 1);
      for (int i = 0; i < 12; i++) begin
         c12 = c12 * bn_type'(SRGB_K);
         rhs = rhs * bn_type'(a);
      end
      rhs = rhs << (5 * (frac + 1));
      // m = 0 always satisfies, m = den never does
      lo = 0;
      hi = den;
      while (hi - lo > 1) begin
         mid = (lo + hi) >> 1;
         mm  = bn_type'(mid);
         lhs = mm * mm * mm * mm * mm * c12;
         if (lhs <= rhs) begin
            lo = mid;
         end else begin
            hi = mid;
         end
      end
      mm  = bn_type'(lo);
      lhs = mm * mm * mm * mm * mm * c12;
      if ((lhs == rhs) && (k % 2 == 1) && (lo > 0)) begin
         lo = lo - 1;
      end
      return 32'(lo);
   endfunction

   // Largest m whose linear-segment byte is at most j, ties to even.
   function automatic logic [31:0] lin_thresh(input int frac, input int j);
      longint den;
      longint num;
      longint q;
      longint r;
      den = longint'(1) << (frac + 1);
      num = longint'(2 * j + 1) * LIN_MUL * den;
      q   = num / LIN_DIV;
      r   = num % LIN_DIV;
      if ((r == 0) && (j % 2 == 1)) begin
         q = q - 1;
      end
      if (q > den - 1) begin
         q = den - 1;
      end
      return 32'(q);
   endfunction

endpackage

`default_nettype wire

@@ sv/slsp_if.sv @@
`default_nettype none

// Pixel request channel: four signed fixed-point channels
interface slsp_req_if;
   logic                              valid;
   logic                              ready;
   logic signed [slsp_pkg::IN_W-1:0]  red_in;
   logic signed [slsp_pkg::IN_W-1:0]  green_in;
   logic signed [slsp_pkg::IN_W-1:0]  blue_in;
   logic signed [slsp_pkg::IN_W-1:0]  alpha_in;

   modport source (output valid, red_in, green_in, blue_in, alpha_in, input ready);
   modport sink   (input valid, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

// Pixel response channel: four encoded bytes
interface slsp_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [slsp_pkg::BYTE_W-1:0]   red_out;
   logic [slsp_pkg::BYTE_W-1:0]   green_out;
   logic [slsp_pkg::BYTE_W-1:0]   blue_out;
   logic [slsp_pkg::BYTE_W-1:0]   alpha_out;

   modport source (output valid, red_out, green_out, blue_out, alpha_out, input ready);
   modport sink   (input valid, red_out, green_out, blue_out, alpha_out, output ready);
endinterface

`default_nettype wire

@@ sv/signed_linear_to_srgb_pixel.sv @@
// Structure: a pixel accepted on req_chan is offered on rsp_chan after
//   nine register stages: input decode, then one stage per output bit of a
//   threshold search over constant tables.
// Throughput: one pixel per clock; each stage holds only while the one after it is full
//   and stalled, so bubbles fill in and input is taken while a result waits.
// Reset: synchronous, active high; clears the stage valid bits only.
`default_nettype none

module signed_linear_to_srgb_pixel #(
   parameter int FRAC_BITS = 14
) (
   input  wire logic       clock,
   input  wire logic       reset,
   slsp_req_if.sink        req_chan,
   slsp_rsp_if.source      rsp_chan
);

   localparam int BW   = slsp_pkg::BYTE_W;
   // Unit-range numerator inside (0, den): FRAC_BITS+1 bits
   localparam int UW   = FRAC_BITS + 1;
   // Signed width of m = x + 2^FRAC_BITS
   localparam int MW   = (FRAC_BITS + 2 > slsp_pkg::IN_W + 1) ? FRAC_BITS + 2
                                                             : slsp_pkg::IN_W + 1;
   localparam int NSTG = BW + 1;

   localparam logic signed [MW-1:0] ONE_M = MW'(longint'(1) << FRAC_BITS);
   localparam logic signed [MW-1:0] DEN_M = MW'(longint'(1) << (FRAC_BITS + 1));
   localparam logic [UW-1:0] HALF_U  = UW'(longint'(1) << FRAC_BITS);
   localparam logic [UW-1:0] LIN_MAX =
      UW'((slsp_pkg::LIN_END_NUM << (FRAC_BITS + 1)) / slsp_pkg::LIN_END_DEN);

   typedef struct packed {
      logic [UW-1:0] mu;    // unit numerator, zero when clamped
      logic          lin;   // on the linear segment
      logic [BW-1:0] code;  // output byte, built one bit per stage
   } chan_type;

   typedef struct packed {
      chan_type [slsp_pkg::NRGB-1:0] ch;
      logic [BW-1:0]                 alpha;
   } pix_type;

   // Byte-boundary tables, worked out at elaboration
   logic [UW-1:0] srgb_tbl [slsp_pkg::NTH];
   logic [UW-1:0] lin_tbl  [slsp_pkg::NTH];

   for (genvar gk = 0; gk < slsp_pkg::NTH; gk++) begin : g_tbl
      assign srgb_tbl[gk] = UW'(slsp_pkg::srgb_thresh(FRAC_BITS, gk));
      assign lin_tbl[gk]  = UW'(slsp_pkg::lin_thresh(FRAC_BITS, gk));
   end

   // Map one color channel to its unit numerator; clamped ends preset the code
   function automatic chan_type dec_chan(input logic signed [slsp_pkg::IN_W-1:0] x);
      logic signed [MW-1:0] m;
      logic                 zero;
      logic                 full;
      chan_type             c;
      m    = MW'(x) + ONE_M;
      zero = m[MW-1] || (m == '0);
      full = !zero && (m >= DEN_M);
      c.mu   = (zero || full) ? '0 : m[UW-1:0];
      c.lin  = (c.mu <= LIN_MAX);
      c.code = full ? '1 : '0;
      return c;
   endfunction

   // Alpha: round(255 * m / den), ties to even
   function automatic logic [BW-1:0] dec_alpha(input logic signed [slsp_pkg::IN_W-1:0] x);
      logic signed [MW-1:0] m;
      logic                 zero;
      logic                 full;
      logic [UW-1:0]        mu;
      logic [UW+BW-1:0]     p;
      logic [BW-1:0]        q;
      logic [UW-1:0]        rem;
      logic                 up;
      m    = MW'(x) + ONE_M;
      zero = m[MW-1] || (m == '0);
      full = !zero && (m >= DEN_M);
      mu   = m[UW-1:0];
      p    = {mu, {BW{1'b0}}} - (UW+BW)'(mu);
      q    = p[UW+BW-1:UW];
      rem  = p[UW-1:0];
      up   = (rem > HALF_U) || ((rem == HALF_U) && q[0]);
      if (zero) begin
         return '0;
      end else if (full) begin
         return '1;
      end
      return q + BW'(up);
   endfunction

   pix_type          stg_ff [NSTG];
   pix_type          stg_in [NSTG];
   logic [NSTG-1:0]  vld_ff;
   logic [NSTG:0]    adv;

   // Per-stage advance: a stage loads when empty or when the next one moves
   assign adv[NSTG] = rsp_chan.ready;
   for (genvar gs = 0; gs < NSTG; gs++) begin : g_adv
      assign adv[gs] = !vld_ff[gs] || adv[gs+1];
   end
   assign req_chan.ready = adv[0];

   // Decode stage
   always_comb begin
      stg_in[0].ch[0] = dec_chan(req_chan.red_in);
      stg_in[0].ch[1] = dec_chan(req_chan.green_in);
      stg_in[0].ch[2] = dec_chan(req_chan.blue_in);
      stg_in[0].alpha = dec_alpha(req_chan.alpha_in);
   end

   // Search stages: stage s settles output bit BW-s of every color channel
   for (genvar gs = 1; gs < NSTG; gs++) begin : g_srch
      localparam logic [BW-1:0] BIT = BW'(1) << (BW - gs);
      logic [BW-1:0] cand [slsp_pkg::NRGB];
      logic [BW-1:0] idx  [slsp_pkg::NRGB];
      logic [UW-1:0] th   [slsp_pkg::NRGB];

      always_comb begin
         stg_in[gs] = stg_ff[gs-1];
         for (int c = 0; c < slsp_pkg::NRGB; c++) begin
            cand[c] = stg_ff[gs-1].ch[c].code | BIT;
            idx[c]  = cand[c] - BW'(1);
            th[c]   = stg_ff[gs-1].ch[c].lin ? lin_tbl[idx[c]] : srgb_tbl[idx[c]];
            if (stg_ff[gs-1].ch[c].mu > th[c]) begin
               stg_in[gs].ch[c].code = cand[c];
            end
         end
      end
   end

   // Stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) begin
            vld_ff[0] <= req_chan.valid;
         end
         for (int s = 1; s < NSTG; s++) begin
            if (adv[s]) begin
               vld_ff[s] <= vld_ff[s-1];
            end
         end
      end
   end

   // Stage payload
   always_ff @(posedge clock) begin
      for (int s = 0; s < NSTG; s++) begin
         if (adv[s]) begin
            stg_ff[s] <= stg_in[s];
         end
      end
   end

   assign rsp_chan.valid     = vld_ff[NSTG-1];
   assign rsp_chan.red_out   = stg_ff[NSTG-1].ch[0].code;
   assign rsp_chan.green_out = stg_ff[NSTG-1].ch[1].code;
   assign rsp_chan.blue_out  = stg_ff[NSTG-1].ch[2].code;
   assign rsp_chan.alpha_out = stg_ff[NSTG-1].alpha;

endmodule

`default_nettype wire

@@ sv/slsp_check.sv @@
`default_nettype none

module slsp_check (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_valid,
   input wire logic                         req_ready,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_ready,
   input wire logic [slsp_pkg::BYTE_W-1:0]  rsp_red,
   input wire logic [slsp_pkg::BYTE_W-1:0]  rsp_green,
   input wire logic [slsp_pkg::BYTE_W-1:0]  rsp_blue,
   input wire logic [slsp_pkg::BYTE_W-1:0]  rsp_alpha
);

   // A stalled response transaction stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // A stalled response transaction keeps its bytes
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(rsp_red) && $stable(rsp_green) && $stable(rsp_blue) && $stable(rsp_alpha))
      else $error("response changed while stalled");

   // Nothing leaves the pipeline right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response offered after reset");

   // Output stage free or draining means the input side takes a transaction
   a_no_block: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid || rsp_ready |-> req_ready)
      else $error("input blocked while output stage can move");

   // An offered response transaction carries known bytes
   a_rsp_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$isunknown({rsp_red, rsp_green, rsp_blue, rsp_alpha}))
      else $error("response bytes unknown");

endmodule

bind signed_linear_to_srgb_pixel slsp_check u_slsp_check (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_red   (rsp_chan.red_out),
   .rsp_green (rsp_chan.green_out),
   .rsp_blue  (rsp_chan.blue_out),
   .rsp_alpha (rsp_chan.alpha_out)
);

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

   localparam int IN_W      = slsp_pkg::IN_W;
   localparam int BYTE_W    = slsp_pkg::BYTE_W;
   localparam int FRAC      = 14;
   localparam int UNIT      = 1 << FRAC;
   localparam longint DEN   = longint'(1) << (FRAC + 1);
   localparam int LIMIT     = 400000;
   localparam int DRAIN_CYC = 20;
   localparam int PHASE_LEN = 350;

   // Power curve byte edges: a_k = (2k+1)*EDGE_STEP + EDGE_OFS, scaled by CURVE_K
   localparam longint CURVE_K   = 538050;
   localparam longint EDGE_STEP = 1000;
   localparam longint EDGE_OFS  = 28050;
   // Linear toe: byte = TOE_MUL * m / (TOE_DIV * den), ends at m*TOE_END_D <= TOE_END_N*den
   localparam longint TOE_MUL   = 16473;
   localparam longint TOE_DIV   = 5;
   localparam longint TOE_END_N = 4045;
   localparam longint TOE_END_D = 1292000;

   typedef bit [383:0] wide_type;

   typedef struct {
      logic signed [IN_W-1:0] red;
      logic signed [IN_W-1:0] green;
      logic signed [IN_W-1:0] blue;
      logic signed [IN_W-1:0] alpha;
      int                     phase;
      bit                     hold;
   } pixel_item_type;

   typedef struct {
      logic [BYTE_W-1:0] red;
      logic [BYTE_W-1:0] green;
      logic [BYTE_W-1:0] blue;
      logic [BYTE_W-1:0] alpha;
   } srgb_bytes_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   slsp_req_if req_chan();
   slsp_rsp_if rsp_chan();

   signed_linear_to_srgb_pixel #(.FRAC_BITS(FRAC)) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Idle rates per phase: sender gaps and receiver stalls, percent of cycles
   int send_idle_pct [3] = '{8, 84, 0};
   int recv_stall_pct[3] = '{84, 8, 0};

   pixel_item_type pixel_q[$];
   srgb_bytes_type encoded_q[$];
   wide_type       byte_edge[0:254];
   wide_type       curve_scale;
   pixel_item_type next_px;
   srgb_bytes_type want;
   int          total_pixels   = 0;
   int          accepted_count = 0;
   int          err_count      = 0;
   int          phase_now      = 0;
   int          cycle_count    = 0;
   bit          req_taken      = 1'b0;

   always #5 clock = ~clock;

   task automatic report_error(input string msg);
      err_count++;
      $display("%0t ns: %s", $time, msg);
   endtask

   // Exact byte edges of the power curve, compared against m^5 * CURVE_K^12
   function automatic void build_edges();
      wide_type a_pow;
      longint   a;
      int       i;
      int       k;
      curve_scale = wide_type'(1);
      for (i = 0; i < 12; i++) curve_scale = curve_scale * wide_type'(CURVE_K);
      for (k = 0; k < 255; k++) begin
         a = longint'(2 * k + 1) * EDGE_STEP + EDGE_OFS;
         a_pow = wide_type'(1);
         for (i = 0; i < 12; i++) a_pow = a_pow * wide_type'(a);
         byte_edge[k] = a_pow << (5 * (FRAC + 1));
      end
   endfunction

   function automatic logic [BYTE_W-1:0] round_even(input longint num, input longint dv);
      longint q;
      longint r;
      q = num / dv;
      r = num % dv;
      if ((2 * r > dv) || ((2 * r == dv) && q[0])) q++;
      return BYTE_W'(q);
   endfunction

   // Alpha: linear map of (x+1)/2 to a byte
   function automatic logic [BYTE_W-1:0] encode_alpha(input logic signed [IN_W-1:0] x);
      longint m;
      m = longint'(x) + UNIT;
      if (m <= 0) return '0;
      if (m >= DEN) return 8'd255;
      return round_even(255 * m, DEN);
   endfunction

   // Color: linear toe, then power segment decided by exact compares
   function automatic logic [BYTE_W-1:0] encode_gamma(input logic signed [IN_W-1:0] x);
      longint   m;
      wide_type p;
      wide_type lhs;
      int       code;
      int       k;
      m = longint'(x) + UNIT;
      if (m <= 0) return '0;
      if (m >= DEN) return 8'd255;
      if (m * TOE_END_D <= TOE_END_N * DEN) return round_even(TOE_MUL * m, TOE_DIV * DEN);
      p    = wide_type'(m);
      lhs  = p * p * p * p * p * curve_scale;
      code = 0;
      for (k = 0; k < 255; k++) begin
         if (lhs > byte_edge[k]) code = k + 1;
      end
      // exactly on an odd edge: tie goes up to the even byte
      if ((code <= 254) && code[0] && (lhs == byte_edge[code])) code++;
      return BYTE_W'(code);
   endfunction

   function automatic srgb_bytes_type encode_pixel(input logic signed [IN_W-1:0] r,
                                                   input logic signed [IN_W-1:0] g,
                                                   input logic signed [IN_W-1:0] b,
                                                   input logic signed [IN_W-1:0] a);
      srgb_bytes_type res;
      res.red   = encode_gamma(r);
      res.green = encode_gamma(g);
      res.blue  = encode_gamma(b);
      res.alpha = encode_alpha(a);
      return res;
   endfunction

   task automatic add_pixel(input int r, input int g, input int b, input int a,
                            input int phase, input bit hold);
      pixel_item_type it;
      it.red   = IN_W'(r);
      it.green = IN_W'(g);
      it.blue  = IN_W'(b);
      it.alpha = IN_W'(a);
      it.phase = phase;
      it.hold  = hold;
      pixel_q.insert(pixel_q.size(), it);
      total_pixels++;
   endtask

   // Mostly the useful -1..+1 span, some near black and the toe, some full range
   function automatic int rand_channel();
      int sel;
      sel = $urandom_range(99);
      if (sel < 15) return -UNIT + int'($urandom_range(400));
      if (sel < 75) return -UNIT + int'($urandom_range(2 * UNIT));
      return int'($signed(16'($urandom)));
   endfunction

   task automatic check_byte(input string name, input logic [BYTE_W-1:0] got,
                             input logic [BYTE_W-1:0] exp_val);
      if (got !== exp_val)
         report_error($sformatf("%s mismatch: got %0d, expected %0d", name, got, exp_val));
   endtask

   // Driver: presents pending pixels, toggles receiver ready
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct[phase_now]);
         if (!req_chan.valid || req_taken) begin
            if ((pixel_q.size() != 0) && !(pixel_q[0].hold && (encoded_q.size() != 0))
                && ($urandom_range(99) >= send_idle_pct[pixel_q[0].phase])) begin
               next_px = pixel_q.pop_front();
               phase_now         <= next_px.phase;
               req_chan.red_in   <= next_px.red;
               req_chan.green_in <= next_px.green;
               req_chan.blue_in  <= next_px.blue;
               req_chan.alpha_in <= next_px.alpha;
               req_chan.valid    <= 1'b1;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: predicts on each accepted pixel, checks each accepted result
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_chan.valid && req_chan.ready;
         if (req_chan.valid && req_chan.ready) begin
            encoded_q.insert(encoded_q.size(),
                             encode_pixel(req_chan.red_in, req_chan.green_in,
                                          req_chan.blue_in, req_chan.alpha_in));
            accepted_count++;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (encoded_q.size() == 0) begin
               report_error("result transaction with no pixel outstanding");
            end else begin
               want = encoded_q.pop_front();
               check_byte("red_out",   rsp_chan.red_out,   want.red);
               check_byte("green_out", rsp_chan.green_out, want.green);
               check_byte("blue_out",  rsp_chan.blue_out,  want.blue);
               check_byte("alpha_out", rsp_chan.alpha_out, want.alpha);
            end
         end
      end
   end

   // Run limit
   initial begin
      while (cycle_count < LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_top: errors");
      $finish;
   end

   initial begin
      req_chan.valid    = 1'b0;
      req_chan.red_in   = '0;
      req_chan.green_in = '0;
      req_chan.blue_in  = '0;
      req_chan.alpha_in = '0;
      rsp_chan.ready    = 1'b0;
      build_edges();

      // Directed: saturation, exact -1/+1, toe end, alpha tie, bit patterns
      add_pixel(-32768, -32768, -32768, -32768, 0, 0);
      add_pixel(32767, 32767, 32767, 32767, 0, 0);
      add_pixel(-UNIT, -UNIT, -UNIT, -UNIT, 0, 0);
      add_pixel(UNIT, UNIT, UNIT, UNIT, 0, 0);
      add_pixel(-UNIT + 1, -UNIT + 1, -UNIT + 1, -UNIT + 1, 0, 0);
      add_pixel(UNIT - 1, UNIT - 1, UNIT - 1, UNIT - 1, 0, 0);
      add_pixel(-UNIT - 1, UNIT + 1, -UNIT - 1, UNIT + 1, 0, 0);
      add_pixel(-UNIT + 102, -UNIT + 102, -UNIT + 102, -UNIT + 102, 0, 0);
      add_pixel(-UNIT + 103, -UNIT + 103, -UNIT + 103, -UNIT + 103, 0, 0);
      add_pixel(-UNIT + 101, -UNIT + 104, -UNIT + 51, -UNIT + 2, 0, 0);
      add_pixel(0, 0, 0, 0, 0, 0);
      add_pixel(-32768, 32767, 0, -UNIT, 0, 0);
      add_pixel(8192, -8192, 4096, -4096, 0, 0);
      add_pixel(-1, 1, -2, 2, 0, 0);
      add_pixel(int'($signed(16'h5555)), int'($signed(16'hAAAA)),
                int'($signed(16'h5555)), int'($signed(16'hAAAA)), 0, 0);
      add_pixel(int'($signed(16'hAAAA)), int'($signed(16'h5555)),
                int'($signed(16'hAAAA)), int'($signed(16'h5555)), 0, 0);
      add_pixel(-UNIT + 200, -UNIT + 300, -UNIT + 1000, UNIT - 64, 0, 0);
      add_pixel(-16000, -12000, 12000, 16000, 0, 0);

      // Random phases; each starts once the pipeline has drained
      for (int ph = 0; ph < 3; ph++) begin
         for (int n = 0; n < PHASE_LEN; n++) begin
            add_pixel(rand_channel(), rand_channel(), rand_channel(), rand_channel(),
                      ph, n == 0);
         end
      end

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait for all pixels accepted and all results seen, then let the pipe settle
      do @(negedge clock);
      while ((accepted_count < total_pixels) || (encoded_q.size() != 0));
      repeat (DRAIN_CYC) @(negedge clock);

      if (encoded_q.size() != 0)
         report_error($sformatf("%0d results never arrived", encoded_q.size()));
      if (err_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
